FILE: rtl/ort_pkg.sv
// Shared types, constants and helpers of the outstanding request tracker.
package ort_pkg;

  localparam int SLOTS      = 32;
  localparam int RESULT_CAP = 32;

  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int CNT_W   = $clog2(RESULT_CAP + 1);
  localparam int DRAW_W  = $clog2(SLOTS + 1);
  localparam int SEQ_W   = 16;
  localparam int TIME_W  = 32;
  localparam int TMO_W   = 24;
  localparam int SLOTF_W = 6;
  localparam int ENTRY_W = SEQ_W + TIME_W;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);
  localparam logic [CNT_W-1:0]  CAP_CNT   = CNT_W'(RESULT_CAP);
  localparam logic [DRAW_W-1:0] MAX_DRAWS = DRAW_W'(SLOTS);
  localparam logic [SEQ_W-1:0]  SEQ_RST   = 16'd1;
  localparam logic [TMO_W-1:0]  TMO_RST   = 24'd5000;

  typedef enum logic [1:0] {
    ACT_CALL  = 2'd0,
    ACT_REPLY = 2'd1,
    ACT_TICK  = 2'd2,
    ACT_NOP   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    KIND_ACCEPTED = 3'd0,
    KIND_REFUSED  = 3'd1,
    KIND_MATCHED  = 3'd2,
    KIND_IGNORED  = 3'd3,
    KIND_TIMEOUT  = 3'd4
  } kind_t;

  typedef struct packed {
    action_t            action;
    logic [TMO_W-1:0]   timeout;
    logic               frame_is_rpc;
    logic [SEQ_W-1:0]   reply_seqno;
    logic [31:0]        reply_status;
  } req_t;

  typedef struct packed {
    kind_t              kind;
    logic [SEQ_W-1:0]   seqno;
    logic [SLOTF_W-1:0] slot;
    logic [31:0]        status;
    logic               last;
  } rsp_t;

  // compare unit results for the entry under scan
  typedef struct packed {
    logic eq;
    logic expired;
  } cmp_t;

  function automatic logic [SLOTF_W-1:0] slot_field(input logic [SLOT_W-1:0] s);
    logic [SLOTF_W-1:0] r;
    r = '0;
    r[SLOT_W-1:0] = s;
    return r;
  endfunction

endpackage

FILE: rtl/ort_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ort_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/ort_cmp.sv
// Shared compare unit: sequence number match and wrapping expiry test.
module ort_cmp (
  input  logic [ort_pkg::SEQ_W-1:0]   key,
  input  logic [ort_pkg::TIME_W-1:0]  now,
  input  logic [ort_pkg::ENTRY_W-1:0] entry,
  output ort_pkg::cmp_t               res
);

  logic [ort_pkg::TIME_W-1:0] diff;

  // expired when (now - expiry) mod 2^32 is below 2^31
  assign diff        = now - entry[ort_pkg::TIME_W-1:0];
  assign res.expired = ~diff[ort_pkg::TIME_W-1];
  assign res.eq      = (entry[ort_pkg::ENTRY_W-1 -: ort_pkg::SEQ_W] == key);

endmodule

FILE: rtl/ort_ctrl.sv
// Sequencer: slot scans, busy bits, counters and the result registers.
module ort_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  ort_pkg::req_t               req,
  input  logic                        req_valid,
  output logic                        req_ready,
  output ort_pkg::rsp_t               rsp,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  input  logic [ort_pkg::TMO_W-1:0]   default_timeout,
  output logic                        ram_we,
  output logic [ort_pkg::SLOT_W-1:0]  ram_waddr,
  output logic [ort_pkg::ENTRY_W-1:0] ram_wdata,
  output logic [ort_pkg::SLOT_W-1:0]  ram_raddr,
  input  logic [ort_pkg::ENTRY_W-1:0] ram_rdata,
  output logic [ort_pkg::SEQ_W-1:0]   cmp_key,
  output logic [ort_pkg::TIME_W-1:0]  cmp_now,
  input  ort_pkg::cmp_t               cmp
);

  typedef enum logic [1:0] {IDLE, PRIME, SCAN, DONE} state_t;

  state_t                      state;
  ort_pkg::action_t            op;
  logic [ort_pkg::SEQ_W-1:0]   key;
  logic [31:0]                 rstatus;
  logic [ort_pkg::TMO_W-1:0]   tmo;
  logic [ort_pkg::SLOT_W-1:0]  idx;
  logic [ort_pkg::SLOT_W-1:0]  found;
  logic                        found_ok;
  logic                        hit;
  logic [ort_pkg::DRAW_W-1:0]  draws;
  logic [ort_pkg::CNT_W-1:0]   cnt;
  logic                        pend_valid;
  ort_pkg::rsp_t               pend;
  logic [ort_pkg::TIME_W-1:0]  now_ticks;
  logic [ort_pkg::SEQ_W-1:0]   next_seq;
  logic [ort_pkg::SLOTS-1:0]   busy;

  logic                        out_free;
  logic                        last_idx;
  logic                        busy_i;
  logic                        exp_now;
  logic                        tick_stall;
  logic                        adv;
  logic [ort_pkg::TMO_W-1:0]   tmo_eff;
  logic [ort_pkg::TIME_W-1:0]  exp_sum;
  logic [ort_pkg::SEQ_W-1:0]   entry_seq;

  assign out_free   = ~rsp_valid | rsp_ready;
  assign last_idx   = (idx == ort_pkg::LAST_SLOT);
  assign busy_i     = busy[idx];
  assign entry_seq  = ram_rdata[ort_pkg::ENTRY_W-1 -: ort_pkg::SEQ_W];
  assign exp_now    = (op == ort_pkg::ACT_TICK) && busy_i && cmp.expired
                      && (cnt < ort_pkg::CAP_CNT);
  // a second expired slot cannot move the held one out while the output is full
  assign tick_stall = exp_now && pend_valid && !out_free;
  assign adv        = (state == SCAN) && !tick_stall;
  assign tmo_eff    = (tmo != '0) ? tmo : default_timeout;
  assign exp_sum    = now_ticks + 32'(tmo_eff);

  // read data always holds the entry of idx while scanning
  always_comb begin
    if (state == SCAN && adv && !last_idx) begin
      ram_raddr = idx + 1'b1;
    end else if (state == SCAN) begin
      ram_raddr = idx;
    end else begin
      ram_raddr = '0;
    end
  end

  assign ram_we    = (state == DONE) && (op == ort_pkg::ACT_CALL) && found_ok && !hit
                     && out_free;
  assign ram_waddr = found;
  assign ram_wdata = {key, exp_sum};
  assign cmp_key   = key;
  assign cmp_now   = now_ticks;
  assign req_ready = (state == IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      busy       <= '0;
      next_seq   <= ort_pkg::SEQ_RST;
      now_ticks  <= '0;
      rsp_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (req_valid) begin
            op       <= req.action;
            tmo      <= req.timeout;
            rstatus  <= req.reply_status;
            draws    <= '0;
            cnt      <= '0;
            found_ok <= 1'b0;
            hit      <= 1'b0;
            unique case (req.action)
              ort_pkg::ACT_CALL: begin
                key   <= next_seq;
                state <= PRIME;
              end
              ort_pkg::ACT_REPLY: begin
                key   <= req.reply_seqno;
                state <= req.frame_is_rpc ? PRIME : DONE;
              end
              ort_pkg::ACT_TICK: begin
                now_ticks <= now_ticks + 1'b1;
                state     <= PRIME;
              end
              default: state <= IDLE;
            endcase
          end
        end
        PRIME: begin
          idx      <= '0;
          found_ok <= 1'b0;
          hit      <= 1'b0;
          state    <= SCAN;
        end
        SCAN: begin
          unique case (op)
            ort_pkg::ACT_CALL: begin
              if (busy_i && cmp.eq) begin
                hit <= 1'b1;
              end
              if (!busy_i && !found_ok) begin
                found_ok <= 1'b1;
                found    <= idx;
              end
              if (last_idx) begin
                state <= DONE;
              end else begin
                idx <= idx + 1'b1;
              end
            end
            ort_pkg::ACT_REPLY: begin
              if (busy_i && cmp.eq) begin
                found_ok <= 1'b1;
                found    <= idx;
                state    <= DONE;
              end else if (last_idx) begin
                state <= DONE;
              end else begin
                idx <= idx + 1'b1;
              end
            end
            ort_pkg::ACT_TICK: begin
              if (!tick_stall) begin
                if (exp_now) begin
                  busy[idx]  <= 1'b0;
                  cnt        <= cnt + 1'b1;
                  pend_valid <= 1'b1;
                  pend       <= '{kind: ort_pkg::KIND_TIMEOUT, seqno: entry_seq,
                                  slot: ort_pkg::slot_field(idx), status: 32'd0,
                                  last: 1'b0};
                  if (pend_valid) begin
                    rsp       <= pend;
                    rsp_valid <= 1'b1;
                  end
                end
                if (last_idx) begin
                  state <= DONE;
                end else begin
                  idx <= idx + 1'b1;
                end
              end
            end
            default: state <= IDLE;
          endcase
        end
        DONE: begin
          unique case (op)
            ort_pkg::ACT_CALL: begin
              if (!found_ok) begin
                // table full: counter untouched
                if (out_free) begin
                  rsp       <= '{kind: ort_pkg::KIND_REFUSED, seqno: '0, slot: '0,
                                 status: 32'd0, last: 1'b1};
                  rsp_valid <= 1'b1;
                  state     <= IDLE;
                end
              end else if (hit && draws == ort_pkg::MAX_DRAWS) begin
                if (out_free) begin
                  next_seq  <= key + 1'b1;
                  rsp       <= '{kind: ort_pkg::KIND_REFUSED, seqno: '0, slot: '0,
                                 status: 32'd0, last: 1'b1};
                  rsp_valid <= 1'b1;
                  state     <= IDLE;
                end
              end else if (hit) begin
                // number in flight: draw the next one and rescan
                key   <= key + 1'b1;
                draws <= draws + 1'b1;
                state <= PRIME;
              end else if (out_free) begin
                busy[found] <= 1'b1;
                next_seq    <= key + 1'b1;
                rsp         <= '{kind: ort_pkg::KIND_ACCEPTED, seqno: key,
                                 slot: ort_pkg::slot_field(found), status: 32'd0,
                                 last: 1'b1};
                rsp_valid   <= 1'b1;
                state       <= IDLE;
              end
            end
            ort_pkg::ACT_REPLY: begin
              if (out_free) begin
                if (found_ok) begin
                  busy[found] <= 1'b0;
                  rsp         <= '{kind: ort_pkg::KIND_MATCHED, seqno: key,
                                   slot: ort_pkg::slot_field(found), status: rstatus,
                                   last: 1'b1};
                end else begin
                  rsp <= '{kind: ort_pkg::KIND_IGNORED, seqno: key, slot: '0,
                           status: 32'd0, last: 1'b1};
                end
                rsp_valid <= 1'b1;
                state     <= IDLE;
              end
            end
            ort_pkg::ACT_TICK: begin
              if (!pend_valid) begin
                state <= IDLE;
              end else if (out_free) begin
                rsp        <= '{kind: pend.kind, seqno: pend.seqno, slot: pend.slot,
                                status: pend.status, last: 1'b1};
                rsp_valid  <= 1'b1;
                pend_valid <= 1'b0;
                state      <= IDLE;
              end
            end
            default: state <= IDLE;
          endcase
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/outstanding_request_tracker.sv
// Top level of the outstanding request tracker.
//
//   channel  signals                          direction  payload
//   -------  -------------------------------  ---------  -----------------------
//   request  req_valid / req_ready / req      in         call, reply or tick
//   result   rsp_valid / rsp_ready / rsp      out        one result transaction
//   config   cfg_wr_en / cfg_wr_data          in         default_timeout
//
// Every call, RPC reply and tick scans the slot table, one slot per cycle unless
// stalled, through a shared compare unit between PRIME and DONE; an RPC reply stops
// at its match. A call rescans for each number found in flight. A non-RPC reply goes
// straight to DONE; idle takes the next request and drops an unused action.
// Reset is synchronous; no clearing pass (RAM data only counts for busy slots). A full
// result register stalls a tick scan at a second expired slot, or holds DONE.
module outstanding_request_tracker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_ready,
  input  ort_pkg::req_t             req,
  output logic                      rsp_valid,
  input  logic                      rsp_ready,
  output ort_pkg::rsp_t             rsp,
  input  logic                      cfg_wr_en,
  input  logic [ort_pkg::TMO_W-1:0] cfg_wr_data
);

  // configuration register: timeout used when a call gives zero
  logic [ort_pkg::TMO_W-1:0]   default_timeout;

  // entry RAM: {seqno, expiry} per slot
  logic                        ram_we;
  logic [ort_pkg::SLOT_W-1:0]  ram_waddr;
  logic [ort_pkg::ENTRY_W-1:0] ram_wdata;
  logic [ort_pkg::SLOT_W-1:0]  ram_raddr;
  logic [ort_pkg::ENTRY_W-1:0] ram_rdata;

  // shared compare unit
  logic [ort_pkg::SEQ_W-1:0]   cmp_key;
  logic [ort_pkg::TIME_W-1:0]  cmp_now;
  ort_pkg::cmp_t               cmp;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_timeout <= ort_pkg::TMO_RST;
    end else if (cfg_wr_en) begin
      default_timeout <= cfg_wr_data;
    end
  end

  ort_ram #(
    .WIDTH (ort_pkg::ENTRY_W),
    .DEPTH (ort_pkg::SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // match on sequence number, expiry test against the current tick count
  ort_cmp u_cmp (
    .key   (cmp_key),
    .now   (cmp_now),
    .entry (ram_rdata),
    .res   (cmp)
  );

  ort_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .req             (req),
    .req_valid       (req_valid),
    .req_ready       (req_ready),
    .rsp             (rsp),
    .rsp_valid       (rsp_valid),
    .rsp_ready       (rsp_ready),
    .default_timeout (default_timeout),
    .ram_we          (ram_we),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata),
    .ram_raddr       (ram_raddr),
    .ram_rdata       (ram_rdata),
    .cmp_key         (cmp_key),
    .cmp_now         (cmp_now),
    .cmp             (cmp)
  );

endmodule
